// File: rtl/software_timer_table_macros.svh
// Assertion macros used by the software timer table checker.
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define STT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/stt_pkg.sv
// Shared types and codes of the software timer table.
package stt_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DEL = 2'd1,
    CMD_MOD = 2'd2,
    CMD_RUN = 2'd3
  } cmd_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  slot;
    logic [31:0] expiry;
    logic [7:0]  handler;
    logic [31:0] payload;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [3:0]  fired_slot;
    logic [7:0]  fired_handler;
    logic [31:0] fired_payload;
  } rsp_t;

endpackage

// File: rtl/stt_ifs.sv
// Request and response channel interfaces of the software timer table.
interface stt_req_if;
  import stt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stt_rsp_if;
  import stt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/software_timer_table.sv
// Software timer table: slot store, insertion order and sequenced scan.
//
// Requests arrive on req (valid/ready) carrying cmd, slot, expiry, handler,
// payload and now; each request gives exactly one response on rsp.
// Add, modify, refused and unarmed-slot delete requests pass from EXEC to DONE.
// Run: EXEC, SCAN, PICK, DONE; one tick subtractor and one order comparator walk
// the slot memories slot by slot, in slot order, behind a registered read port.
// Delete of an armed slot: EXEC, FETCH, SWEEP, DONE; the same walk closes up the
// insertion order with one order-memory write for each armed slot behind it.
// req.ready is high only while the sequencer is idle, from the cycle after the
// previous response is loaded, so a new request is taken only once the last
// one has its response loaded.
// The response register holds its result while rsp.ready is low; a new
// request is still taken and worked, and its result waits for the register.
// Reset (rst, synchronous) disarms every slot and clears the armed count;
// the slot memories need no clearing because the armed bits guard them.
module software_timer_table #(
  parameter int SLOTS      = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  stt_req_if.sink   req,
  stt_rsp_if.source rsp
);
  import stt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_SWEEP = 7'b0010000,
    S_PICK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                  state;
  cmd_t                    cmd_r;
  logic [3:0]              slot_r;
  logic [TICK_WIDTH-1:0]   expiry_r;
  logic [7:0]              handler_r;
  logic [31:0]             payload_r;
  logic [TICK_WIDTH-1:0]   now_r;
  logic [SLOTS-1:0]        armed;
  logic [CW-1:0]           armed_count;
  logic [SW-1:0]           rd_idx;
  logic [SW-1:0]           pos_ref;
  logic                    found;
  logic [SW-1:0]           best_slot;
  logic [SW-1:0]           best_pos;
  logic [7:0]              best_handler;
  logic [31:0]             best_payload;
  rsp_t                    res;
  rsp_t                    out_data;
  logic                    out_valid;

  logic [TICK_WIDTH-1:0]   exp_mem [SLOTS];
  logic [7:0]              hnd_mem [SLOTS];
  logic [31:0]             pay_mem [SLOTS];
  logic [SW-1:0]           ord_mem [SLOTS];
  logic [TICK_WIDTH-1:0]   exp_rd;
  logic [7:0]              hnd_rd;
  logic [31:0]             pay_rd;
  logic [SW-1:0]           ord_rd;

  logic [SW-1:0]           slot_idx;
  logic                    in_range;
  logic                    last;
  logic [SW-1:0]           rd_addr;
  logic [TICK_WIDTH-1:0]   tick_b;
  logic [TICK_WIDTH-1:0]   tick_diff;
  logic                    reached;
  logic                    add_ok;
  logic                    scan_hit;
  logic                    sweep_dec;
  logic                    exp_we;
  logic                    fill_we;
  logic                    ord_we;
  logic [SW-1:0]           ord_wa;
  logic [SW-1:0]           ord_wd;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign slot_idx = SW'(slot_r);
  assign in_range = (32'(slot_r) < 32'(SLOTS));
  assign last     = (rd_idx == SW'(SLOTS - 1));

  // shared tick unit: wrap-safe "now has reached expiry"
  assign tick_b    = (state == S_SCAN) ? exp_rd : expiry_r;
  assign tick_diff = now_r - tick_b;
  assign reached   = !tick_diff[TICK_WIDTH-1];

  assign add_ok    = in_range && !armed[slot_idx] && !reached;
  assign scan_hit  = armed[rd_idx] && reached && (!found || (ord_rd < best_pos));
  assign sweep_dec = (state == S_SWEEP) && armed[rd_idx] && (ord_rd > pos_ref);

  always_comb begin
    unique case (state)
      S_EXEC:          rd_addr = (cmd_r == CMD_DEL) ? slot_idx : '0;
      S_SCAN, S_SWEEP: rd_addr = last ? '0 : rd_idx + SW'(1);
      default:         rd_addr = '0;
    endcase
  end

  always_comb begin
    exp_we  = 1'b0;
    fill_we = 1'b0;
    ord_we  = 1'b0;
    ord_wa  = slot_idx;
    ord_wd  = SW'(armed_count);
    if (state == S_EXEC && in_range) begin
      case (cmd_r)
        CMD_ADD: begin
          exp_we  = add_ok;
          fill_we = add_ok;
          ord_we  = add_ok;
        end
        CMD_MOD: exp_we = 1'b1;
        default: exp_we = 1'b0;
      endcase
    end
    if (sweep_dec) begin
      ord_we = 1'b1;
      ord_wa = rd_idx;
      ord_wd = ord_rd - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    exp_rd <= exp_mem[rd_addr];
    hnd_rd <= hnd_mem[rd_addr];
    pay_rd <= pay_mem[rd_addr];
    ord_rd <= ord_mem[rd_addr];
    if (exp_we) begin
      exp_mem[slot_idx] <= expiry_r;
    end
    if (fill_we) begin
      hnd_mem[slot_idx] <= handler_r;
      pay_mem[slot_idx] <= payload_r;
    end
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
  end

  // request capture, delete order reference and scan datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd_r     <= req.data.cmd;
      slot_r    <= req.data.slot;
      expiry_r  <= TICK_WIDTH'(req.data.expiry);
      handler_r <= req.data.handler;
      payload_r <= req.data.payload;
      now_r     <= TICK_WIDTH'(req.data.now);
    end
    if (state == S_FETCH) begin
      pos_ref <= ord_rd;
    end
    if (state == S_SCAN && scan_hit) begin
      best_slot    <= rd_idx;
      best_pos     <= ord_rd;
      best_handler <= hnd_rd;
      best_payload <= pay_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      armed       <= '0;
      armed_count <= '0;
      found       <= 1'b0;
      rd_idx      <= '0;
      res         <= '0;
      out_data    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res    <= '0;
          rd_idx <= '0;
          found  <= 1'b0;
          state  <= S_DONE;
          if (cmd_r == CMD_RUN) begin
            state <= S_SCAN;
          end else if (!in_range) begin
            res.status <= STATUS_REFUSED;
          end else begin
            case (cmd_r)
              CMD_ADD: begin
                if (add_ok) begin
                  armed[slot_idx] <= 1'b1;
                  armed_count     <= armed_count + CW'(1);
                end else begin
                  res.status <= STATUS_REFUSED;
                end
              end
              CMD_DEL: begin
                if (armed[slot_idx]) begin
                  state <= S_FETCH;
                end
              end
              default: res.status <= STATUS_OK;
            endcase
          end
        end
        S_FETCH: begin
          armed[slot_idx] <= 1'b0;
          if (armed_count != '0) begin
            armed_count <= armed_count - CW'(1);
          end
          rd_idx <= '0;
          state  <= S_SWEEP;
        end
        S_SCAN: begin
          if (scan_hit) begin
            found <= 1'b1;
          end
          if (last) begin
            state <= S_PICK;
          end else begin
            rd_idx <= rd_idx + SW'(1);
          end
        end
        S_SWEEP: begin
          if (last) begin
            state <= S_DONE;
          end else begin
            rd_idx <= rd_idx + SW'(1);
          end
        end
        S_PICK: begin
          if (found && best_handler != 8'd0) begin
            res.fired         <= 1'b1;
            res.fired_slot    <= 4'(best_slot);
            res.fired_handler <= best_handler;
            res.fired_payload <= best_payload;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/stt_checker.sv
// Port-level checker of the software timer table and its bind.
`include "software_timer_table_macros.svh"

module stt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input stt_pkg::rsp_t rsp_data
);
  import stt_pkg::*;

  logic [1:0] pending;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // count requests taken and not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (req_acc && !rsp_acc) begin
      pending <= pending + 2'd1;
    end else if (!req_acc && rsp_acc) begin
      pending <= pending - 2'd1;
    end
  end

  `STT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
  `STT_ASSERT_NEXT(a_busy_after_req, req_acc, !req_ready, "request taken while previous one still in work")
  `STT_ASSERT_NOW(a_rsp_owed, rsp_valid, pending != 2'd0, "response without an outstanding request")
  `STT_ASSERT_NOW(a_fired_sane, rsp_valid && rsp_data.fired, (rsp_data.status == STATUS_OK) && (rsp_data.fired_handler != 8'd0), "fired response with refusal or null handler")

endmodule

bind software_timer_table stt_checker u_stt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
